// ----- rtl/rmq_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the rotation matrix to quaternion pipeline.
// No dependencies.
package rmq_pkg;

   // width of every matrix and quaternion field
   localparam int FIELD_W = 16;

   // saturation limits of a result field
   localparam logic signed [FIELD_W-1:0] SAT_MAX = 16'sh7fff;
   localparam logic signed [FIELD_W-1:0] SAT_MIN = 16'sh8000;

   // magnitude limits in a 32-bit compare domain
   localparam logic [31:0] POS_LIMIT = 32'd32767;
   localparam logic [31:0] NEG_LIMIT = 32'd32768;

endpackage

// ----- rtl/rmq_channels.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for matrix requests and quaternion results.
// Depends on rmq_pkg.
interface rmq_req_if import rmq_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   input ready);
   modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   output ready);
endinterface

interface rmq_rsp_if import rmq_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] q_w, q_x, q_y, q_z;

   modport source (output valid, q_w, q_x, q_y, q_z, input ready);
   modport sink   (input valid, q_w, q_x, q_y, q_z, output ready);
endinterface

// ----- rtl/rmq_form.sv -----
`timescale 1ns / 1ps
// Front end: picks the Shepperd path, forms the unscaled quaternion,
// squares it and sums the squares. Three register stages. Depends on rmq_pkg.
module rmq_form import rmq_pkg::*; #(
   parameter int FRAC_BITS = 14,
   parameter int QW        = 19,
   parameter int SW        = 38
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic signed [FIELD_W-1:0] in_m [9],
   output logic                      out_valid,
   output logic signed [QW-1:0]      out_q [4],
   output logic        [SW-1:0]      out_s
);

   localparam logic signed [QW-1:0] ONE = QW'(1) << FRAC_BITS;

   logic signed [QW-1:0] e [9];
   logic signed [QW-1:0] trace;
   logic                 trace_pos;
   logic                 gt_10;
   logic                 gt_2k;
   logic signed [FIELD_W-1:0] diag_max;
   logic signed [QW-1:0] q_in [4];
   logic signed [QW-1:0] q1_ff [4];
   logic signed [QW-1:0] q2_ff [4];
   logic signed [QW-1:0] q3_ff [4];
   logic        [QW-1:0] mag [4];
   logic        [SW-1:0] sq_in [4];
   logic        [SW-1:0] sq_ff [4];
   logic        [SW-1:0] s_ff;
   logic                 v1_ff, v2_ff, v3_ff;

   // sign-extend the matrix and select the path
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         e[i] = QW'(in_m[i]);
      end
      trace     = e[0] + e[4] + e[8];
      trace_pos = trace > 0;
      gt_10     = in_m[4] > in_m[0];
      diag_max  = gt_10 ? in_m[4] : in_m[0];
      gt_2k     = in_m[8] > diag_max;
      priority if (trace_pos) begin
         q_in[0] = ONE + trace;
         q_in[1] = e[7] - e[5];
         q_in[2] = e[2] - e[6];
         q_in[3] = e[3] - e[1];
      end else if (gt_2k) begin
         q_in[0] = e[3] - e[1];
         q_in[1] = e[2] + e[6];
         q_in[2] = e[5] + e[7];
         q_in[3] = ONE - e[0] - e[4] + e[8];
      end else if (gt_10) begin
         q_in[0] = e[2] - e[6];
         q_in[1] = e[1] + e[3];
         q_in[2] = ONE + e[4] - e[0] - e[8];
         q_in[3] = e[5] + e[7];
      end else begin
         q_in[0] = e[7] - e[5];
         q_in[1] = ONE + e[0] - e[4] - e[8];
         q_in[2] = e[1] + e[3];
         q_in[3] = e[2] + e[6];
      end
   end

   // square the magnitudes
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mag[i]   = q1_ff[i][QW-1] ? QW'(-q1_ff[i]) : QW'(q1_ff[i]);
         sq_in[i] = mag[i] * mag[i];
      end
   end

   // advance the three stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q1_ff <= q_in;
         q2_ff <= q1_ff;
         sq_ff <= sq_in;
         q3_ff <= q2_ff;
         s_ff  <= sq_ff[0] + sq_ff[1] + sq_ff[2] + sq_ff[3];
      end
   end

   assign out_valid = v3_ff;
   assign out_q     = q3_ff;
   assign out_s     = s_ff;

endmodule

// ----- rtl/rmq_isqrt.sv -----
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage, with the
// quaternion carried alongside. Depends on rmq_pkg.
module rmq_isqrt import rmq_pkg::*; #(
   parameter int QW = 19,
   parameter int SW = 38
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [QW-1:0] in_q [4],
   input  logic        [SW-1:0] in_s,
   output logic                 out_valid,
   output logic signed [QW-1:0] out_q [4],
   output logic        [QW-1:0] out_n
);

   logic        [SW-1:0] rem_ff  [QW];
   logic        [QW-1:0] root_ff [QW];
   logic signed [QW-1:0] q_ff    [QW][4];
   logic                 v_ff    [QW];

   for (genvar j = 0; j < QW; j++) begin : g_stage
      localparam int B = QW - 1 - j;

      logic        [SW-1:0] rem_prev;
      logic        [QW-1:0] root_prev;
      logic signed [QW-1:0] q_prev [4];
      logic                 v_prev;
      logic        [SW-1:0] trial;
      logic        [SW-1:0] rem_in;
      logic        [QW-1:0] root_in;

      if (j == 0) begin : g_first
         assign rem_prev  = in_s;
         assign root_prev = '0;
         assign q_prev    = in_q;
         assign v_prev    = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign q_prev    = q_ff[j-1];
         assign v_prev    = v_ff[j-1];
      end

      // try setting this root bit
      always_comb begin
         trial = (SW'(root_prev) << (B + 1)) | (SW'(1) << (2 * B));
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            root_in = root_prev | (QW'(1) << B);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en) begin
            v_ff[j] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            q_ff[j]    <= q_prev;
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign out_q     = q_ff[QW-1];
   assign out_n     = root_ff[QW-1];

endmodule

// ----- rtl/rmq_divide.sv -----
`timescale 1ns / 1ps
// Pipelined rounding division of the four components by the length,
// one quotient bit per stage, then saturation. Depends on rmq_pkg.
module rmq_divide import rmq_pkg::*; #(
   parameter int FRAC_BITS = 14,
   parameter int QW        = 19
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic signed [QW-1:0]      in_q [4],
   input  logic        [QW-1:0]      in_n,
   output logic                      out_valid,
   output logic signed [FIELD_W-1:0] out_q [4]
);

   localparam int NUMW = QW + FRAC_BITS + 1;
   localparam int DEP  = FRAC_BITS + 1;

   // numerator stage
   logic [NUMW-1:0]      num_ff [4];
   logic [QW:0]          d0_ff;
   logic                 neg0_ff [4];
   logic                 zero0_ff;
   logic                 v0_ff;
   logic [QW-1:0]        mag [4];

   // division stages
   logic [NUMW-1:0]      rem_ff  [DEP][4];
   logic [FRAC_BITS:0]   quo_ff  [DEP][4];
   logic [QW:0]          d_ff    [DEP];
   logic                 neg_ff  [DEP][4];
   logic                 zero_ff [DEP];
   logic                 v_ff    [DEP];

   // output register
   logic signed [FIELD_W-1:0] res_in [4];
   logic signed [FIELD_W-1:0] res_ff [4];
   logic                      vo_ff;
   logic [31:0]               r32 [4];

   // form 2*|q|*one + n and the divisor 2*n
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mag[i] = in_q[i][QW-1] ? QW'(-in_q[i]) : QW'(in_q[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            num_ff[i]  <= (NUMW'(mag[i]) << (FRAC_BITS + 1)) + NUMW'(in_n);
            neg0_ff[i] <= in_q[i][QW-1];
         end
         d0_ff    <= {in_n, 1'b0};
         zero0_ff <= in_n == '0;
      end
   end

   for (genvar j = 0; j < DEP; j++) begin : g_stage
      localparam int B = FRAC_BITS - j;

      logic [NUMW-1:0]    rem_prev [4];
      logic [FRAC_BITS:0] quo_prev [4];
      logic [QW:0]        d_prev;
      logic               neg_prev [4];
      logic               zero_prev;
      logic               v_prev;
      logic [NUMW-1:0]    test;
      logic [NUMW-1:0]    rem_in [4];
      logic [FRAC_BITS:0] quo_in [4];

      if (j == 0) begin : g_first
         assign rem_prev  = num_ff;
         assign quo_prev  = '{default: '0};
         assign d_prev    = d0_ff;
         assign neg_prev  = neg0_ff;
         assign zero_prev = zero0_ff;
         assign v_prev    = v0_ff;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign quo_prev  = quo_ff[j-1];
         assign d_prev    = d_ff[j-1];
         assign neg_prev  = neg_ff[j-1];
         assign zero_prev = zero_ff[j-1];
         assign v_prev    = v_ff[j-1];
      end

      // subtract the shifted divisor where it fits
      always_comb begin
         test = NUMW'(d_prev) << B;
         for (int i = 0; i < 4; i++) begin
            if (rem_prev[i] >= test) begin
               rem_in[i] = rem_prev[i] - test;
               quo_in[i] = quo_prev[i] | ((FRAC_BITS + 1)'(1) << B);
            end else begin
               rem_in[i] = rem_prev[i];
               quo_in[i] = quo_prev[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en) begin
            v_ff[j] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            quo_ff[j]  <= quo_in;
            d_ff[j]    <= d_prev;
            neg_ff[j]  <= neg_prev;
            zero_ff[j] <= zero_prev;
         end
      end
   end

   // apply sign and clamp to the field range
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         r32[i] = 32'(quo_ff[DEP-1][i]);
         if (zero_ff[DEP-1]) begin
            res_in[i] = '0;
         end else if (neg_ff[DEP-1][i]) begin
            res_in[i] = (r32[i] > NEG_LIMIT) ? SAT_MIN : FIELD_W'(-r32[i]);
         end else begin
            res_in[i] = (r32[i] > POS_LIMIT) ? SAT_MAX : FIELD_W'(r32[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
         vo_ff <= v_ff[DEP-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = vo_ff;
   assign out_q     = res_ff;

endmodule

// ----- rtl/rotation_matrix_to_quaternion.sv -----
`timescale 1ns / 1ps
// Rotation matrix to unit quaternion, Shepperd's method, fully pipelined.
// QW = max(FRAC_BITS, 17) + 2 (19 at Q2.14); the pipe depth is set by the
// bit-per-stage square root and the bit-per-stage divider.
// Throughput: one request per cycle; a stalled result freezes the whole pipe.
// Reset (synchronous) clears all valid bits; the data registers are not reset.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
   parameter int FRAC_BITS = 14
) (
   input  logic             clock,
   input  logic             reset,
   rmq_req_if.sink          req_chan,
   rmq_rsp_if.source        rsp_chan
);

   localparam int QW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
   localparam int SW = 2 * QW;

   logic                      en;
   logic signed [FIELD_W-1:0] m_in [9];
   logic                      form_valid;
   logic signed [QW-1:0]      form_q [4];
   logic        [SW-1:0]      form_s;
   logic                      root_valid;
   logic signed [QW-1:0]      root_q [4];
   logic        [QW-1:0]      root_n;
   logic signed [FIELD_W-1:0] res_q [4];

   // advance every stage unless the result is held
   assign en             = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = en;

   assign m_in[0] = req_chan.m00;
   assign m_in[1] = req_chan.m01;
   assign m_in[2] = req_chan.m02;
   assign m_in[3] = req_chan.m10;
   assign m_in[4] = req_chan.m11;
   assign m_in[5] = req_chan.m12;
   assign m_in[6] = req_chan.m20;
   assign m_in[7] = req_chan.m21;
   assign m_in[8] = req_chan.m22;

   rmq_form #(.FRAC_BITS(FRAC_BITS), .QW(QW), .SW(SW)) u_form (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .in_m      (m_in),
      .out_valid (form_valid),
      .out_q     (form_q),
      .out_s     (form_s)
   );

   rmq_isqrt #(.QW(QW), .SW(SW)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (form_valid),
      .in_q      (form_q),
      .in_s      (form_s),
      .out_valid (root_valid),
      .out_q     (root_q),
      .out_n     (root_n)
   );

   rmq_divide #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_divide (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (root_valid),
      .in_q      (root_q),
      .in_n      (root_n),
      .out_valid (rsp_chan.valid),
      .out_q     (res_q)
   );

   assign rsp_chan.q_w = res_q[0];
   assign rsp_chan.q_x = res_q[1];
   assign rsp_chan.q_y = res_q[2];
   assign rsp_chan.q_z = res_q[3];

   // a held result blocks new requests, a free output takes them
   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready == (!rsp_chan.valid || rsp_chan.ready))
      else $error("request ready does not track output stall");

   // reset empties the pipe
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result valid right after reset");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for rotation_matrix_to_quaternion: directed table, back-pressure run, then random matrices.
// Depends on rmq_pkg, rmq_channels and the RTL top level.
module tb;
   import rmq_pkg::*;

   localparam int FRAC      = 14;
   localparam int LATENCY   = 39;
   localparam int N_RANDOM  = 1650;
   localparam int CYCLE_CAP = 400000;

   typedef logic signed [FIELD_W-1:0] fld_type;
   typedef struct packed {
      fld_type m00, m01, m02, m10, m11, m12, m20, m21, m22;
   } mat_type;
   typedef struct packed {
      fld_type w, x, y, z;
   } quat_type;
   typedef struct {
      mat_type  mat;
      bit       known;
      quat_type q;
   } row_type;

   logic clock;
   logic reset;
   rmq_req_if req_chan ();
   rmq_rsp_if rsp_chan ();

   rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   quat_type  quat_queue[$];
   int        errors      = 0;
   int        sent        = 0;
   int        received    = 0;
   int        cycles      = 0;
   bit        hold_off    = 0;
   bit        calm        = 0;
   row_type   directed[$];

   // integer square root, floor
   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // scale one component by one/n, round half away, saturate
   function automatic fld_type scale_part(longint q, longint unsigned n);
      longint unsigned mag, r;
      mag = (q < 0) ? longint'(-q) : longint'(q);
      if (n == 0) return '0;
      r = (2 * mag * (64'd1 << FRAC) + n) / (2 * n);
      if (q < 0) return (r > 32768) ? SAT_MIN : fld_type'(-longint'(r));
      return (r > 32767) ? SAT_MAX : fld_type'(r);
   endfunction

   // Shepperd conversion of one matrix
   function automatic quat_type shepperd_quat(mat_type m);
      longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, one;
      longint v[4];
      longint unsigned s, n;
      int k;
      quat_type q;
      a00 = m.m00; a01 = m.m01; a02 = m.m02;
      a10 = m.m10; a11 = m.m11; a12 = m.m12;
      a20 = m.m20; a21 = m.m21; a22 = m.m22;
      one = 64'sd1 << FRAC;
      tr  = a00 + a11 + a22;
      if (tr > 0) begin
         v = '{one + tr, a21 - a12, a02 - a20, a10 - a01};
      end else begin
         k = 0;
         if (a11 > a00) k = 1;
         if (a22 > ((k == 1) ? a11 : a00)) k = 2;
         case (k)
            0: v = '{a21 - a12, one + a00 - a11 - a22, a01 + a10, a02 + a20};
            1: v = '{a02 - a20, a01 + a10, one + a11 - a00 - a22, a12 + a21};
            default: v = '{a10 - a01, a02 + a20, a12 + a21, one - a00 - a11 + a22};
         endcase
      end
      s = 0;
      foreach (v[i]) s += longint'(v[i] * v[i]);
      n = int_sqrt(s);
      q.w = scale_part(v[0], n);
      q.x = scale_part(v[1], n);
      q.y = scale_part(v[2], n);
      q.z = scale_part(v[3], n);
      return q;
   endfunction

   function automatic mat_type diag_mat(int d0, int d1, int d2);
      mat_type m;
      m = '0;
      m.m00 = fld_type'(d0); m.m11 = fld_type'(d1); m.m22 = fld_type'(d2);
      return m;
   endfunction

   // random matrix: mostly entries in [-16384, 16384], sometimes raw noise or extreme diagonals
   function automatic mat_type random_mat();
      mat_type m;
      int sel;
      sel = $urandom_range(0, 9);
      m = mat_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      if (sel < 6) begin
         m.m00 = fld_type'($signed($urandom_range(0, 32768)) - 16384);
         m.m01 = fld_type'($signed($urandom_range(0, 32768)) - 16384);
         m.m02 = fld_type'($signed($urandom_range(0, 32768)) - 16384);
         m.m10 = fld_type'($signed($urandom_range(0, 32768)) - 16384);
         m.m11 = fld_type'($signed($urandom_range(0, 32768)) - 16384);
         m.m12 = fld_type'($signed($urandom_range(0, 32768)) - 16384);
         m.m20 = fld_type'($signed($urandom_range(0, 32768)) - 16384);
         m.m21 = fld_type'($signed($urandom_range(0, 32768)) - 16384);
         m.m22 = fld_type'($signed($urandom_range(0, 32768)) - 16384);
      end else if (sel == 6) begin
         m.m00 = $urandom_range(0, 1) ? SAT_MAX : SAT_MIN;
         m.m11 = $urandom_range(0, 1) ? SAT_MAX : SAT_MIN;
         m.m22 = $urandom_range(0, 1) ? SAT_MAX : SAT_MIN;
      end
      return m;
   endfunction

   // clock
   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // result side: random stalls, long hold-off on request
   initial begin
      rsp_chan.ready = 0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= !hold_off && (calm || $urandom_range(0, 99) >= 9);
      end
   end

   // check every accepted result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         quat_type exp_q;
         received++;
         if (quat_queue.size() == 0) begin
            $error("result with no prediction pending");
            errors++;
         end else begin
            exp_q = quat_queue.pop_front();
            if (rsp_chan.q_w !== exp_q.w) begin
               $error("q_w exp %0d got %0d", exp_q.w, rsp_chan.q_w); errors++;
            end
            if (rsp_chan.q_x !== exp_q.x) begin
               $error("q_x exp %0d got %0d", exp_q.x, rsp_chan.q_x); errors++;
            end
            if (rsp_chan.q_y !== exp_q.y) begin
               $error("q_y exp %0d got %0d", exp_q.y, rsp_chan.q_y); errors++;
            end
            if (rsp_chan.q_z !== exp_q.z) begin
               $error("q_z exp %0d got %0d", exp_q.z, rsp_chan.q_z); errors++;
            end
         end
      end
   end

   // present one request and hold it until accepted
   task automatic send_request(mat_type m, quat_type q);
      while (!calm && $urandom_range(0, 99) < 9) begin
         req_chan.valid <= 0;
         @(posedge clock);
      end
      req_chan.valid <= 1;
      {req_chan.m00, req_chan.m01, req_chan.m02, req_chan.m10, req_chan.m11,
       req_chan.m12, req_chan.m20, req_chan.m21, req_chan.m22} <= m;
      do @(posedge clock); while (!req_chan.ready);
      quat_queue.push_back(q);
      sent++;
   endtask

   task automatic drain();
      req_chan.valid <= 0;
      @(posedge clock);
      while (quat_queue.size() != 0) @(posedge clock);
   endtask

   initial begin
      row_type r;
      mat_type m;
      req_chan.valid = 0;
      {req_chan.m00, req_chan.m01, req_chan.m02, req_chan.m10, req_chan.m11,
       req_chan.m12, req_chan.m20, req_chan.m21, req_chan.m22} = '0;
      reset = 1;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed rows: identity and half-turns have obvious answers
      directed.push_back('{diag_mat(16384, 16384, 16384), 1, '{16384, 0, 0, 0}});
      directed.push_back('{diag_mat(16384, -16384, -16384), 1, '{0, 16384, 0, 0}});
      directed.push_back('{diag_mat(-16384, 16384, -16384), 1, '{0, 0, 16384, 0}});
      directed.push_back('{diag_mat(-16384, -16384, 16384), 1, '{0, 0, 0, 16384}});
      // zero matrix: trace zero, tie goes to index 0
      directed.push_back('{diag_mat(0, 0, 0), 1, '{0, 16384, 0, 0}});
      // ties among the diagonal
      directed.push_back('{diag_mat(-100, -100, -100), 0, '{default: 0}});
      directed.push_back('{diag_mat(-200, -100, -100), 0, '{default: 0}});
      directed.push_back('{diag_mat(SAT_MAX, SAT_MAX, SAT_MAX), 0, '{default: 0}});
      directed.push_back('{diag_mat(SAT_MIN, SAT_MIN, SAT_MIN), 0, '{default: 0}});
      directed.push_back('{diag_mat(SAT_MIN, SAT_MAX, SAT_MIN), 0, '{default: 0}});
      directed.push_back('{diag_mat(SAT_MIN, SAT_MIN, SAT_MAX), 0, '{default: 0}});
      directed.push_back('{diag_mat(1, 0, 0), 0, '{default: 0}});
      // 90 degree about z
      m = '0; m.m01 = -16384; m.m10 = 16384; m.m22 = 16384;
      directed.push_back('{m, 0, '{default: 0}});
      directed.push_back('{mat_type'({9{SAT_MAX}}), 0, '{default: 0}});
      directed.push_back('{mat_type'({9{SAT_MIN}}), 0, '{default: 0}});
      directed.push_back('{mat_type'({9{16'sh5555}}), 0, '{default: 0}});
      directed.push_back('{mat_type'({9{16'shaaaa}}), 0, '{default: 0}});
      m = mat_type'({9{SAT_MIN}}); m.m00 = SAT_MAX; m.m11 = SAT_MAX; m.m22 = SAT_MAX;
      directed.push_back('{m, 0, '{default: 0}});

      foreach (directed[i]) begin
         r = directed[i];
         send_request(r.mat, r.known ? r.q : shepperd_quat(r.mat));
      end
      drain();

      // back-pressure: hold results off while requests keep coming
      fork
         begin
            hold_off = 1;
            repeat (200) @(posedge clock);
            hold_off = 0;
         end
         repeat (150) begin
            m = random_mat();
            send_request(m, shepperd_quat(m));
         end
      join
      drain();

      for (int i = 0; i < N_RANDOM; i++) begin
         calm = (i >= 600 && i < 900);
         m = random_mat();
         send_request(m, shepperd_quat(m));
      end
      drain();
      repeat (LATENCY + 10) @(posedge clock);

      $display("Sent %0d matrices (directed, back-pressure, random); checked %0d quaternions.",
               sent, received);
      if (errors == 0 && quat_queue.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule

// ----- rotation_matrix_to_quaternion.f -----
rtl/rmq_pkg.sv
rtl/rmq_channels.sv
rtl/rmq_form.sv
rtl/rmq_isqrt.sv
rtl/rmq_divide.sv
rtl/rotation_matrix_to_quaternion.sv
test/tb.sv
